// File: sv/mcb_pkg.sv
// Shared types and constants for the message channel buffer.
package mcb_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned StepW  = 24;
  localparam int unsigned MaxFields = 4;
  localparam int unsigned AddrW  = 4;

  localparam logic [1:0] RegSlots  = 2'd0;
  localparam logic [1:0] RegFields = 2'd1;
  localparam logic [1:0] RegLose   = 2'd2;

  localparam logic FuncSend = 1'b0;
  localparam logic FuncRecv = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the input item
    logic apply;    // update the cell chain with the computed operation
    logic load_out; // register the result item
  } mcb_cmd_t;

  // Datapath status toward the controller.
  typedef struct packed {
    logic busy;
  } mcb_stat_t;

endpackage

// File: sv/mcb_ctrl.sv
// Controller: sequences capture, compute/apply and result handoff.
module mcb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mcb_pkg::mcb_cmd_t cmd
);

  typedef enum logic [0:0] {ST_IDLE, ST_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic accept_in;
  logic out_free;

  // Result register is free when empty or being taken this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept_in = in_valid && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.capture   = accept_in;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_in) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.apply     = 1'b1;
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> !accept_in) else $error("accept while busy");
  a_exec_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_free) |=> state_r == ST_IDLE && out_valid_r)
    else $error("result not produced");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r) else $error("result dropped");
`endif

endmodule

// File: sv/mcb_datapath.sv
// Datapath: cell chain of held messages with parallel compare and shift.
module mcb_datapath #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned FIELDS = 4,
  parameter int unsigned CntW   = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mcb_pkg::mcb_cmd_t        cmd,
  input  logic [CntW-1:0]          cap_cfg,
  input  logic [2:0]               nf_cfg,
  input  logic                     lose_cfg,
  input  logic                     in_func,
  input  logic [1:0]               in_mode,
  input  logic                     in_commit,
  input  logic [3:0]               in_match_mask,
  input  logic [23:0]              in_step_number,
  input  logic signed [31:0]       in_value [mcb_pkg::MaxFields],
  output logic                     out_ok,
  output logic signed [31:0]       out_value [mcb_pkg::MaxFields],
  output logic [23:0]              out_step_out,
  output logic [4:0]               out_queue_length
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Cell chain storage.
  logic [31:0] msg_r  [SLOTS][FIELDS];
  logic [23:0] step_r [SLOTS];
  logic [CntW-1:0] held_r, held_nxt;

  // Captured item.
  logic        func_r, commit_r;
  logic [1:0]  mode_r;
  logic [3:0]  mask_r;
  logic [23:0] stepin_r;
  logic [31:0] val_r [FIELDS];

  logic        ok_r;
  logic [31:0] outv_r [mcb_pkg::MaxFields];
  logic [23:0] outs_r;
  logic [4:0]  qlen_r;

  // Clamped configuration.
  logic [CntW-1:0] cap;
  logic [2:0]      nf;
  always_comb begin
    cap = cap_cfg;
    if (cap_cfg == '0) cap = CntW'(1);
    else if (cap_cfg > CntW'(SLOTS)) cap = CntW'(SLOTS);
    nf = nf_cfg;
    if (nf_cfg == 3'd0) nf = 3'd1;
    else if (nf_cfg > 3'(FIELDS)) nf = 3'(FIELDS);
  end

  // Per-cell compare: greater-than (for sorted insert) and mask match.
  logic [SLOTS-1:0] gt, match, live;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      logic decided, g, m;
      decided = 1'b0;
      g = 1'b0;
      m = 1'b1;
      for (int j = 0; j < FIELDS; j++) begin
        if (3'(j) < nf) begin
          if (!decided && val_r[j] != msg_r[i][j]) begin
            decided = 1'b1;
            g = $signed(val_r[j]) < $signed(msg_r[i][j]);
          end
          if (mask_r[j] && msg_r[i][j] != val_r[j]) m = 1'b0;
        end
      end
      live[i]  = CntW'(i) < held_r;
      gt[i]    = g && live[i];
      match[i] = m && live[i];
    end
  end

  // Priority pick of first hit.
  logic [IdxW-1:0] ins_pos, hit_pos;
  logic            found;
  logic            full;
  always_comb begin
    ins_pos = held_r[IdxW-1:0];
    if (mode_r != 2'd0) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (gt[i]) ins_pos = IdxW'(i);
    end
    found   = 1'b0;
    hit_pos = '0;
    if (mode_r[0]) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (match[i]) begin
        found = 1'b1;
        hit_pos = IdxW'(i);
      end
    end else begin
      found = match[0];
    end
  end

  assign full = held_r >= cap;

  logic do_send, do_recv, send_ok;
  assign send_ok = !full;
  assign do_send = func_r == mcb_pkg::FuncSend && send_ok && commit_r;
  assign do_recv = func_r == mcb_pkg::FuncRecv && found && commit_r && !mode_r[1];

  always_comb begin
    held_nxt = held_r;
    if (do_send) held_nxt = held_r + CntW'(1);
    else if (do_recv) held_nxt = held_r - CntW'(1);
  end

  // Capture item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= in_func;
      mode_r   <= in_mode;
      commit_r <= in_commit;
      mask_r   <= in_match_mask;
      stepin_r <= in_step_number;
      for (int j = 0; j < FIELDS; j++) val_r[j] <= in_value[j];
    end
  end

  // Shift the cell chain.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (do_send) begin
          if (IdxW'(i) == ins_pos) begin
            for (int j = 0; j < FIELDS; j++)
              msg_r[i][j] <= (3'(j) < nf) ? val_r[j] : 32'd0;
            step_r[i] <= stepin_r;
          end else if (IdxW'(i) > ins_pos && i > 0) begin
            msg_r[i]  <= msg_r[(i > 0) ? i - 1 : 0];
            step_r[i] <= step_r[(i > 0) ? i - 1 : 0];
          end
        end else if (do_recv) begin
          if (IdxW'(i) >= hit_pos && i < SLOTS - 1) begin
            msg_r[i]  <= msg_r[(i < SLOTS - 1) ? i + 1 : i];
            step_r[i] <= step_r[(i < SLOTS - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) held_r <= '0;
    else if (cmd.apply) held_r <= held_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int j = 0; j < mcb_pkg::MaxFields; j++) outv_r[j] <= 32'd0;
      outs_r <= 24'd0;
      qlen_r <= 5'(held_nxt);
      if (func_r == mcb_pkg::FuncSend) begin
        ok_r <= send_ok || lose_cfg;
      end else begin
        ok_r <= found;
        if (found) begin
          for (int j = 0; j < FIELDS; j++)
            if (3'(j) < nf) outv_r[j] <= msg_r[hit_pos][j];
          outs_r <= step_r[hit_pos];
        end
      end
    end
  end

  assign out_ok           = ok_r;
  assign out_step_out     = outs_r;
  assign out_queue_length = qlen_r;
  always_comb for (int j = 0; j < mcb_pkg::MaxFields; j++) out_value[j] = outv_r[j];

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CntW'(SLOTS)) else $error("held count overflow");
  a_send_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && do_send) |=> held_r == $past(held_r) + CntW'(1))
    else $error("send count");
  a_recv_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && do_recv) |=> held_r == $past(held_r) - CntW'(1))
    else $error("receive count");
`endif

endmodule

// File: sv/message_channel_buffer_core.sv
// Top level of the message channel buffer.
// Usage:
//  in_* channel carries one send or receive item; out_* returns one
//  result item per input item (ok, matched fields, step, queue length).
//  Each item is captured, then takes one pass of the parallel
//  compare/shift cell chain; a new item is accepted once the result is
//  registered, and the pass waits while a stalled result is held.
//  The cfg_* APB port sets capacity, field count and drop-when-full;
//  write it only while the block is idle. pready is always high.
//  Reset (rst_n low, synchronous) empties the channel and restores
//  capacity SLOTS (at most 31), FIELDS fields and refusal on full.
//  While out_stall is high the result holds and at most one further
//  item is held in work until the result register frees.
module message_channel_buffer_core #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned FIELDS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [1:0]         in_mode,
  input  logic               in_commit,
  input  logic [3:0]         in_match_mask,
  input  logic [23:0]        in_step_number,
  input  logic signed [31:0] in_value0,
  input  logic signed [31:0] in_value1,
  input  logic signed [31:0] in_value2,
  input  logic signed [31:0] in_value3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic signed [31:0] out_value0,
  output logic signed [31:0] out_value1,
  output logic signed [31:0] out_value2,
  output logic signed [31:0] out_value3,
  output logic [23:0]        out_step_out,
  output logic [4:0]         out_queue_length,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CntW = $clog2(SLOTS + 1);

  logic [4:0] slots_r;
  logic [2:0] fields_r;
  logic       lose_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r  <= 5'(SLOTS > 31 ? 31 : SLOTS);
      fields_r <= 3'(FIELDS);
      lose_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        mcb_pkg::RegSlots:  slots_r  <= pwdata[4:0];
        mcb_pkg::RegFields: fields_r <= pwdata[2:0];
        mcb_pkg::RegLose:   lose_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      mcb_pkg::RegSlots:  prdata = {27'd0, slots_r};
      mcb_pkg::RegFields: prdata = {29'd0, fields_r};
      mcb_pkg::RegLose:   prdata = {31'd0, lose_r};
      default:            prdata = 32'd0;
    endcase
  end

  mcb_pkg::mcb_cmd_t cmd;

  mcb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  logic signed [31:0] vin  [mcb_pkg::MaxFields];
  logic signed [31:0] vout [mcb_pkg::MaxFields];
  assign vin[0] = in_value0;
  assign vin[1] = in_value1;
  assign vin[2] = in_value2;
  assign vin[3] = in_value3;
  assign out_value0 = vout[0];
  assign out_value1 = vout[1];
  assign out_value2 = vout[2];
  assign out_value3 = vout[3];

  // Capacity limited to SLOTS, compared at full width.
  logic [CntW-1:0] cap_w;
  assign cap_w = (32'(slots_r) > SLOTS) ? CntW'(SLOTS) : CntW'(slots_r);

  mcb_datapath #(.SLOTS(SLOTS), .FIELDS(FIELDS), .CntW(CntW)) u_dp (
    .clk, .rst_n, .cmd,
    .cap_cfg(cap_w), .nf_cfg(fields_r), .lose_cfg(lose_r),
    .in_func, .in_mode, .in_commit, .in_match_mask, .in_step_number,
    .in_value(vin),
    .out_ok, .out_value(vout), .out_step_out, .out_queue_length
  );

endmodule
